### design/spectral_bin_excess_detector_core_macros.svh
// Assertion macros shared by the detector RTL.
// Needs nothing else; the synthesis build sees empty bodies.
`ifndef SPECTRAL_BIN_EXCESS_DETECTOR_CORE_MACROS_SVH
`define SPECTRAL_BIN_EXCESS_DETECTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define SBED_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sbed: same-cycle check failed");
// next-cycle implication, held off during reset
`define SBED_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sbed: next-cycle check failed");
`else
`define SBED_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBED_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/sbed_pkg.sv
// Shared types, constants and helpers of the spectral bin excess detector.
// No dependencies; imported by the top, the front and the back end.
`default_nettype none
package sbed_pkg;

  localparam int unsigned BinsDefault = 64;
  localparam int unsigned BinW        = 6;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned PowerW      = 2 * CoordW;
  localparam int unsigned ExpW        = 5;
  localparam int unsigned FracW       = 3;
  localparam int unsigned LevelW      = ExpW + FracW;
  localparam int unsigned ExcessW     = 8;
  localparam int unsigned FracQ       = 8;
  localparam int unsigned BaseW       = 16;
  localparam int unsigned FloorW      = 31;
  localparam int unsigned GainW       = 8;
  localparam int unsigned ShiftW      = 4;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 31;

  localparam int unsigned MidDepth    = 8;
  localparam int unsigned MidCntW     = $clog2(MidDepth + 1);
  localparam int unsigned OutDepth    = 4;
  localparam int unsigned OutCntW     = $clog2(OutDepth + 1);

  localparam logic [BaseW-1:0]  BaseMax           = 16'hFFFF;
  localparam logic [FloorW-1:0] PowerFloorReset   = '0;
  localparam logic [GainW-1:0]  DevGainReset      = 8'd48;
  localparam logic [BaseW-1:0]  TrigMarginReset   = 16'd256;
  localparam logic [ShiftW-1:0] AdaptShiftReset   = 4'd4;
  localparam logic [BaseW-1:0]  DevFloorReset     = 16'd64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPowerFloor = 3'd0,
    CfgDevGain    = 3'd1,
    CfgTrigMargin = 3'd2,
    CfgAdaptShift = 3'd3,
    CfgDevFloor   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [FloorW-1:0] power_floor;
    logic [GainW-1:0]  dev_gain;
    logic [BaseW-1:0]  trigger_margin;
    logic [ShiftW-1:0] adapt_shift;
    logic [BaseW-1:0]  dev_floor;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [BinW-1:0]   bin;
    logic              learn;
    logic              in_range;
    logic [LevelW-1:0] level;
  } mid_item_t;

  typedef struct packed {
    logic [BinW-1:0]    bin;
    logic [LevelW-1:0]  level;
    logic [ExcessW-1:0] excess;
  } res_item_t;

  // position of the highest set bit, 0 for a zero word
  function automatic logic [ExpW-1:0] msb_index(input logic [PowerW-1:0] v);
    logic [ExpW-1:0] idx;
    idx = '0;
    for (int i = 0; i < PowerW; i++) begin
      if (v[i]) idx = ExpW'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

### design/spectral_bin_excess_detector_core.sv
// Spectral bin excess detector top: config registers, front, queues, back.
// Depends on sbed_pkg, sbed_front, sbed_back, sbed_fifo and the macros header.
// Path: front stages, middle queue, back stages and result queue, in that order.
// Throughput: one request per cycle while full is low, bounded by the single baseline RAM port pair.
// Reset: config takes its reset values, both queues empty, baselines read as zero
// through per-bin valid bits; no clearing pass, requests are taken right after reset.
`default_nettype none
`include "spectral_bin_excess_detector_core_macros.svh"
module spectral_bin_excess_detector_core
  import sbed_pkg::*;
#(
  parameter int unsigned BINS = BinsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration writes
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_wdata_i,
  // request side
  input  logic                     push,
  output logic                     full,
  input  logic [BinW-1:0]          bin_index_i,
  input  logic signed [CoordW-1:0] re_part_i,
  input  logic signed [CoordW-1:0] im_part_i,
  input  logic                     mode_i,
  // result side
  output logic                     empty,
  input  logic                     pop,
  output logic [BinW-1:0]          out_bin_o,
  output logic [LevelW-1:0]        level_o,
  output logic [ExcessW-1:0]       excess_o
);

  cfg_t cfg_q;

  logic               mid_push, mid_pop, mid_empty;
  mid_item_t          mid_wr_item, mid_rd_item;
  logic [MidCntW-1:0] mid_count;

  logic               res_push;
  res_item_t          res_wr_item, res_rd_item;
  logic [OutCntW-1:0] out_count;

  // Config registers. Writes must only land while the block is idle; the block
  // does not enforce this, and the pipeline reads them live without shadowing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_floor    <= PowerFloorReset;
      cfg_q.dev_gain       <= DevGainReset;
      cfg_q.trigger_margin <= TrigMarginReset;
      cfg_q.adapt_shift    <= AdaptShiftReset;
      cfg_q.dev_floor      <= DevFloorReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgPowerFloor: cfg_q.power_floor    <= cfg_wdata_i[FloorW-1:0];
        CfgDevGain:    cfg_q.dev_gain       <= cfg_wdata_i[GainW-1:0];
        CfgTrigMargin: cfg_q.trigger_margin <= cfg_wdata_i[BaseW-1:0];
        CfgAdaptShift: cfg_q.adapt_shift    <= cfg_wdata_i[ShiftW-1:0];
        CfgDevFloor:   cfg_q.dev_floor      <= cfg_wdata_i[BaseW-1:0];
        default: ; // unknown index: write dropped
      endcase
    end
  end

  // Front: three stages (squares, power sum, leading-one search), then the
  // level is formed and the classified request goes into the middle queue.
  // It reserves a queue slot per request, so full is the only back-pressure.
  sbed_front #(
    .BINS (BINS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .bin_index_i (bin_index_i),
    .re_part_i   (re_part_i),
    .im_part_i   (im_part_i),
    .mode_i      (mode_i),
    .mid_count_i (mid_count),
    .full_o      (full),
    .mid_push_o  (mid_push),
    .mid_item_o  (mid_wr_item)
  );

  // Middle queue decouples the front from baseline access.
  sbed_fifo #(
    .Width ($bits(mid_item_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wr_item),
    .pop_i   (mid_pop),
    .rdata_o (mid_rd_item),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  // Back: RAM read, then update and write-back with one-entry bypass for a
  // bin hit twice in a row, then the trigger compare.
  sbed_back #(
    .BINS (BINS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_rd_item),
    .mid_pop_o   (mid_pop),
    .out_count_i (out_count),
    .res_push_o  (res_push),
    .res_item_o  (res_wr_item)
  );

  // Result queue: the consumer may stall without holding up the back end
  // until the queue fills.
  sbed_fifo #(
    .Width ($bits(res_item_t)),
    .Depth (OutDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wr_item),
    .pop_i   (pop),
    .rdata_o (res_rd_item),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_bin_o = res_rd_item.bin;
  assign level_o   = res_rd_item.level;
  assign excess_o  = res_rd_item.excess;

  // credit bookkeeping must keep both queues from overflowing
  `SBED_ASSERT_IMP(a_mid_no_overflow, clk_i, rst_ni, mid_push, (mid_count < MidCntW'(MidDepth)))
  `SBED_ASSERT_IMP(a_res_no_overflow, clk_i, rst_ni, res_push, (out_count < OutCntW'(OutDepth)))
  `SBED_ASSERT_IMP(a_full_when_queue_full, clk_i, rst_ni, (mid_count == MidCntW'(MidDepth)), full)
  `SBED_ASSERT_NXT(a_pop_feeds_result, clk_i, rst_ni, mid_pop, ##1 res_push)

endmodule
`default_nettype wire

### design/sbed_fifo.sv
// Small flop-based FIFO, used for the front-to-back queue and the result queue.
// No dependencies.
`default_nettype none
module sbed_fifo #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [Width-1:0]             wdata_i,
  input  logic                         pop_i,
  output logic [Width-1:0]             rdata_o,
  output logic                         empty_o,
  output logic [$clog2(Depth+1)-1:0]   count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign do_push = push_i && (count_q != CntW'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule
`default_nettype wire

### design/sbed_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; a read and a write to one address in a cycle return old data.
`default_nettype none
module sbed_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(Depth)-1:0]   wr_addr_i,
  input  logic [Width-1:0]           wr_data_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(Depth)-1:0]   rd_addr_i,
  output logic [Width-1:0]           rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

### design/sbed_front.sv
// Front end: takes input requests, squares and sums the bin, forms the log2 level.
// Depends on sbed_pkg; feeds the front-to-back queue by credit, so it never stalls.
`default_nettype none
module sbed_front
  import sbed_pkg::*;
#(
  parameter int unsigned BINS = BinsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     push_i,
  input  logic [BinW-1:0]          bin_index_i,
  input  logic signed [CoordW-1:0] re_part_i,
  input  logic signed [CoordW-1:0] im_part_i,
  input  logic                     mode_i,
  input  logic [MidCntW-1:0]       mid_count_i,
  output logic                     full_o,
  output logic                     mid_push_o,
  output mid_item_t                mid_item_o
);

  localparam int unsigned BinLimit = (BINS < (1 << BinW)) ? BINS : (1 << BinW);

  logic s1_v_q, s2_v_q, s3_v_q;
  mid_item_t s1_tag_q, s2_tag_q, s3_tag_q;
  logic [PowerW-1:0] sq_re_q, sq_im_q, pwr_q, pwr3_q;
  logic [ExpW-1:0]   exp_q;
  logic              nz_q;

  logic               accept;
  logic [MidCntW:0]   credit_used;
  logic signed [PowerW-1:0] sq_re_d, sq_im_d;
  mid_item_t          tag_d;
  logic [PowerW-1:0]  norm;
  logic [FracW-1:0]   frac;

  // every request in flight holds a queue slot
  assign credit_used = {1'b0, mid_count_i} + (MidCntW+1)'(s1_v_q)
                     + (MidCntW+1)'(s2_v_q) + (MidCntW+1)'(s3_v_q);
  assign full_o = (credit_used >= (MidCntW+1)'(MidDepth));
  assign accept = push_i && !full_o;

  assign sq_re_d = re_part_i * re_part_i;
  assign sq_im_d = im_part_i * im_part_i;

  always_comb begin
    tag_d          = '0;
    tag_d.bin      = bin_index_i;
    tag_d.learn    = mode_i;
    tag_d.in_range = ({1'b0, bin_index_i} < (BinW+1)'(BinLimit));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= tag_d;
    sq_re_q  <= $unsigned(sq_re_d);
    sq_im_q  <= $unsigned(sq_im_d);
    s2_tag_q <= s1_tag_q;
    pwr_q    <= sq_re_q + sq_im_q + {1'b0, cfg_i.power_floor};
    s3_tag_q <= s2_tag_q;
    pwr3_q   <= pwr_q;
    exp_q    <= msb_index(pwr_q);
    nz_q     <= (pwr_q != '0);
  end

  // left-justify so the leading one sits at the top with the three bits under it
  assign norm = pwr3_q << (ExpW'(PowerW - 1) - exp_q);
  assign frac = norm[PowerW-2 -: FracW];

  always_comb begin
    mid_item_o       = s3_tag_q;
    mid_item_o.level = nz_q ? {exp_q, frac} : '0;
  end
  assign mid_push_o = s3_v_q;

endmodule
`default_nettype wire

### design/sbed_back.sv
// Back end: baseline read-modify-write per bin, trigger compare and excess.
// Depends on sbed_pkg and sbed_ram; issues into the result queue by credit.
`default_nettype none
module sbed_back
  import sbed_pkg::*;
#(
  parameter int unsigned BINS = BinsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               mid_empty_i,
  input  mid_item_t          mid_item_i,
  output logic               mid_pop_o,
  input  logic [OutCntW-1:0] out_count_i,
  output logic               res_push_o,
  output res_item_t          res_item_o
);

  localparam int unsigned UsedBins = (BINS < (1 << BinW)) ? BINS : (1 << BinW);
  localparam int unsigned AddrW    = $clog2(UsedBins);
  localparam int unsigned ProdW    = GainW + BaseW;
  localparam int unsigned TrigW    = ProdW - 3;
  localparam int unsigned SW       = BaseW + 2;

  logic                  pop;
  logic [OutCntW:0]      credit_used;
  logic [AddrW-1:0]      rd_addr, b2_addr;
  logic                  vbit_d;
  logic [2*BaseW-1:0]    rd_data;

  logic                  b2_v_q, b2_vbit_q;
  mid_item_t             b2_item_q;
  logic                  b3_v_q;
  mid_item_t             b3_item_q;
  logic [BaseW-1:0]      b3_mean_q;
  logic [ProdW-1:0]      b3_prod_q;

  logic [UsedBins-1:0]   valid_q;
  logic                  lw_v_q;
  logic [AddrW-1:0]      lw_addr_q;
  logic [BaseW-1:0]      lw_mean_q, lw_dev_q;

  logic                  fwd, we;
  logic [BaseW-1:0]      mean_cur, dev_cur, ad, mean_new, dev_new;
  logic signed [SW-1:0]  x_s, d_s, mstep_s, mean_s, ddiff_s, dstep_s, dev_s;
  logic [ProdW-1:0]      prod_d;
  logic [TrigW-1:0]      x_t, trig, diff;

  // ---- stage 1: pop and read the baseline
  assign credit_used = {1'b0, out_count_i} + (OutCntW+1)'(b2_v_q) + (OutCntW+1)'(b3_v_q);
  assign pop       = !mid_empty_i && (credit_used < (OutCntW+1)'(OutDepth));
  assign mid_pop_o = pop;
  assign rd_addr   = mid_item_i.bin[AddrW-1:0];
  assign vbit_d    = mid_item_i.in_range && valid_q[rd_addr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_v_q  <= 1'b0;
      b3_v_q  <= 1'b0;
      valid_q <= '0;
      lw_v_q  <= 1'b0;
    end else begin
      b2_v_q <= pop;
      b3_v_q <= b2_v_q;
      if (we) begin
        valid_q[b2_addr] <= 1'b1;
        lw_v_q           <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b2_item_q <= mid_item_i;
      b2_vbit_q <= vbit_d;
    end
    if (we) begin
      lw_addr_q <= b2_addr;
      lw_mean_q <= mean_new;
      lw_dev_q  <= dev_new;
    end
    b3_item_q <= b2_item_q;
    b3_mean_q <= mean_cur;
    b3_prod_q <= prod_d;
  end

  sbed_ram #(
    .Width (2 * BaseW),
    .Depth (UsedBins)
  ) u_base_ram (
    .clk_i     (clk_i),
    .wr_en_i   (we),
    .wr_addr_i (b2_addr),
    .wr_data_i ({mean_new, dev_new}),
    .rd_en_i   (pop && mid_item_i.in_range),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // ---- stage 2: baseline with bypass of the write made as it was read
  assign b2_addr = b2_item_q.bin[AddrW-1:0];
  assign fwd     = lw_v_q && (lw_addr_q == b2_addr);
  assign we      = b2_v_q && b2_item_q.learn && b2_item_q.in_range;

  always_comb begin
    mean_cur = '0;
    dev_cur  = '0;
    if (b2_item_q.in_range) begin
      if (fwd) begin
        mean_cur = lw_mean_q;
        dev_cur  = lw_dev_q;
      end else if (b2_vbit_q) begin
        mean_cur = rd_data[2*BaseW-1:BaseW];
        dev_cur  = rd_data[BaseW-1:0];
      end
    end
  end

  assign prod_d = cfg_i.dev_gain * dev_cur;

  always_comb begin
    x_s     = $signed({2'b00, b2_item_q.level, {FracQ{1'b0}}});
    d_s     = x_s - $signed({2'b00, mean_cur});
    ad      = d_s[SW-1] ? BaseW'(-d_s) : d_s[BaseW-1:0];
    mstep_s = d_s >>> cfg_i.adapt_shift;
    mean_s  = $signed({2'b00, mean_cur}) + mstep_s;
    ddiff_s = $signed({2'b00, ad}) - $signed({2'b00, dev_cur});
    dstep_s = ddiff_s >>> cfg_i.adapt_shift;
    dev_s   = $signed({2'b00, dev_cur}) + dstep_s;

    if (mean_s[SW-1]) begin
      mean_new = '0;
    end else if (mean_s[BaseW]) begin
      mean_new = BaseMax;
    end else begin
      mean_new = mean_s[BaseW-1:0];
    end

    if (dev_s < $signed({2'b00, cfg_i.dev_floor})) begin
      dev_new = cfg_i.dev_floor;
    end else if (dev_s[BaseW]) begin
      dev_new = BaseMax;
    end else begin
      dev_new = dev_s[BaseW-1:0];
    end
  end

  // ---- stage 3: trigger and excess
  assign x_t  = TrigW'({b3_item_q.level, {FracQ{1'b0}}});
  assign trig = TrigW'(b3_mean_q) + TrigW'(b3_prod_q >> 4) + TrigW'(cfg_i.trigger_margin);
  assign diff = x_t - trig;

  always_comb begin
    res_item_o        = '0;
    res_item_o.bin    = b3_item_q.bin;
    res_item_o.level  = b3_item_q.level;
    res_item_o.excess = (x_t > trig) ? diff[FracQ +: ExcessW] : '0;
  end
  assign res_push_o = b3_v_q;

endmodule
`default_nettype wire

### tb/sbed_bin_checker.sv
// Scoreboard for the spectral bin excess detector: watches the register, request
// and result channels, predicts level and excess per bin and compares in order.
// Depends on sbed_pkg for widths, register codes and the result item type.
`timescale 1ns / 1ps
module sbed_bin_checker
  import sbed_pkg::*;
#(
  parameter int unsigned BINS = BinsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_wdata_i,
  input  logic                     push,
  input  logic                     full,
  input  logic [BinW-1:0]          bin_index_i,
  input  logic signed [CoordW-1:0] re_part_i,
  input  logic signed [CoordW-1:0] im_part_i,
  input  logic                     mode_i,
  input  logic                     empty,
  input  logic                     pop,
  input  logic [BinW-1:0]          out_bin_o,
  input  logic [LevelW-1:0]        level_o,
  input  logic [ExcessW-1:0]       excess_o,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o
);

  cfg_t             settings;
  logic [BaseW-1:0] mean_mem [BINS];
  logic [BaseW-1:0] dev_mem  [BINS];
  res_item_t        score_q [$];
  int unsigned      fails;
  int unsigned      checked;

  // floor(log2) * 8 plus the three bits below the leading one
  function automatic logic [LevelW-1:0] log_level(input logic [PowerW-1:0] pwr);
    int unsigned      lead;
    logic [PowerW-1:0] aligned;
    lead = 0;
    for (int i = 0; i < PowerW; i++) begin
      if (pwr[i]) lead = i;
    end
    if (pwr == '0) return '0;
    aligned = (lead >= FracW) ? (pwr >> (lead - FracW)) : (pwr << (FracW - lead));
    return LevelW'((lead << FracW) | (aligned & 32'd7));
  endfunction

  // score one bin against its baseline, then learn if asked
  function automatic res_item_t score_bin(input logic [BinW-1:0] bin,
                                          input logic signed [CoordW-1:0] re,
                                          input logic signed [CoordW-1:0] im,
                                          input logic learn);
    res_item_t         r;
    logic              in_range;
    int unsigned       mean, dev, gain, trig, x;
    logic [PowerW-1:0] pwr;
    int                sr, si, m, dv, d, ad, lo;
    in_range = (bin < BINS);
    mean = 0;
    dev = 0;
    if (in_range) begin
      mean = mean_mem[bin];
      dev = dev_mem[bin];
    end
    sr = re;
    si = im;
    pwr = PowerW'(sr * sr) + PowerW'(si * si) + PowerW'(settings.power_floor);
    r.bin = bin;
    r.level = log_level(pwr);
    x = r.level;
    x = x << FracQ;
    gain = settings.dev_gain;
    trig = mean + ((gain * dev) >> 4) + settings.trigger_margin;
    r.excess = (x > trig) ? ExcessW'((x - trig) >> FracQ) : '0;
    if (learn && in_range) begin
      m = mean;
      dv = dev;
      d = int'(x) - m;
      ad = (d < 0) ? -d : d;
      // >>> on a signed int rounds toward minus infinity
      m += d >>> settings.adapt_shift;
      dv += (ad - dv) >>> settings.adapt_shift;
      lo = settings.dev_floor;
      if (m < 0) m = 0;
      if (m > int'(BaseMax)) m = BaseMax;
      if (dv < lo) dv = lo;
      if (dv > int'(BaseMax)) dv = BaseMax;
      mean_mem[bin] = BaseW'(m);
      dev_mem[bin] = BaseW'(dv);
    end
    return r;
  endfunction

  function automatic bit field_matches(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
    if (got === want) return 1'b1;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_item_t want;
    if (!rst_ni) begin
      settings = '{power_floor: PowerFloorReset, dev_gain: DevGainReset,
                   trigger_margin: TrigMarginReset, adapt_shift: AdaptShiftReset,
                   dev_floor: DevFloorReset};
      for (int i = 0; i < BINS; i++) begin
        mean_mem[i] = '0;
        dev_mem[i] = '0;
      end
      score_q.delete();
      fails = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPowerFloor: settings.power_floor = cfg_wdata_i[FloorW-1:0];
          CfgDevGain:    settings.dev_gain = cfg_wdata_i[GainW-1:0];
          CfgTrigMargin: settings.trigger_margin = cfg_wdata_i[BaseW-1:0];
          CfgAdaptShift: settings.adapt_shift = cfg_wdata_i[ShiftW-1:0];
          CfgDevFloor:   settings.dev_floor = cfg_wdata_i[BaseW-1:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (score_q.size() == 0) begin
          $display("%0t: unexpected result: bin %0d level %0d excess %0d",
                   $time, out_bin_o, level_o, excess_o);
          fails++;
        end else begin
          want = score_q.pop_front();
          checked++;
          if (!field_matches("out_bin", 8'(want.bin), 8'(out_bin_o))) fails++;
          if (!field_matches("level", want.level, level_o)) fails++;
          if (!field_matches("excess", want.excess, excess_o)) fails++;
        end
      end
      if (push && !full) begin
        score_q.push_back(score_bin(bin_index_i, re_part_i, im_part_i, mode_i));
      end
    end
    fail_count_o <= fails;
    pending_o <= score_q.size();
    checked_o <= checked;
  end

endmodule

### tb/tb_top.sv
// Top of the detector testbench: clock, reset, request and register stimulus,
// result drain with random stalls, and the verdict.
// Depends on sbed_pkg, spectral_bin_excess_detector_core and sbed_bin_checker.
`timescale 1ns / 1ps
module tb_top;
  import sbed_pkg::*;

  localparam int unsigned BINS           = BinsDefault;
  localparam int unsigned RxHoldCycles   = 200;  // long result stall, fills the block
  localparam int unsigned DrainCycles    = 12;   // past the pipeline latency
  localparam int unsigned RandomPhase0   = 60;
  localparam int unsigned RandomPerPhase = 80;
  localparam int unsigned SettingsCount  = 6;
  localparam logic [CfgIdxW-1:0] CfgFirstSpare = CfgDevFloor + 1;

  typedef struct packed {
    logic [BinW-1:0]   bin;
    logic [CoordW-1:0] re;
    logic [CoordW-1:0] im;
    logic              learn;
  } bin_req_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [CfgDataW-1:0]      cfg_wdata_i = '0;
  logic                     push = 1'b0;
  logic                     full;
  logic [BinW-1:0]          bin_index_i = '0;
  logic signed [CoordW-1:0] re_part_i = '0;
  logic signed [CoordW-1:0] im_part_i = '0;
  logic                     mode_i = 1'b0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [BinW-1:0]          out_bin_o;
  logic [LevelW-1:0]        level_o;
  logic [ExcessW-1:0]       excess_o;

  int unsigned score_fails, scores_pending, scores_checked;
  int unsigned sent_reqs = 0;
  int unsigned full_stall_cycles = 0;
  int unsigned rx_holds_wanted = 0;
  int unsigned rx_holds_done = 0;

  // hot bins of the current phase, each with its own typical magnitude
  int unsigned hot_base, hot_span;
  int unsigned typical_amp [BINS];

  always #5 clk_i = ~clk_i;

  spectral_bin_excess_detector_core #(.BINS(BINS)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .bin_index_i, .re_part_i, .im_part_i, .mode_i,
    .empty, .pop, .out_bin_o, .level_o, .excess_o
  );

  sbed_bin_checker #(.BINS(BINS)) i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .bin_index_i, .re_part_i, .im_part_i, .mode_i,
    .empty, .pop, .out_bin_o, .level_o, .excess_o,
    .fail_count_o(score_fails), .pending_o(scores_pending), .checked_o(scores_checked)
  );

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bin_req_t req(input int unsigned bin, input int re, input int im,
                                   input bit learn);
    bin_req_t r;
    r.bin = BinW'(bin);
    r.re = CoordW'(re);
    r.im = CoordW'(im);
    r.learn = learn;
    return r;
  endfunction

  // Mostly well-formed learn traffic on a few hot bins around their typical
  // magnitude, so baselines settle and the trigger actually matters; the rest
  // is energy bursts on those bins and fully random requests.
  function automatic bin_req_t random_req();
    bin_req_t    r;
    int unsigned pick, a;
    int          re_v, im_v;
    pick = $urandom_range(0, 99);
    r.learn = ($urandom_range(0, 9) != 0);
    if (pick < 70) begin
      r.bin = BinW'(hot_base + $urandom_range(0, hot_span - 1));
      a = typical_amp[r.bin];
      re_v = a + $urandom_range(0, a / 4);
      im_v = $urandom_range(0, a / 2);
      if ($urandom_range(0, 1)) re_v = -re_v;
      if ($urandom_range(0, 1)) im_v = -im_v;
      r.re = CoordW'(re_v);
      r.im = CoordW'(im_v);
    end else if (pick < 85) begin
      r.bin = BinW'(hot_base + $urandom_range(0, hot_span - 1));
      r.re = CoordW'($urandom);
      r.re[CoordW-2] = 1'b1;
      r.im = CoordW'($urandom);
    end else begin
      r.bin = BinW'($urandom);
      r.re = CoordW'($urandom);
      r.im = CoordW'($urandom);
      r.learn = $urandom_range(0, 1);
    end
    return r;
  endfunction

  // the only place push is lowered, so it never gets two updates in one step
  task automatic idle_sender(input int unsigned cycles);
    if (cycles != 0) begin
      push <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // present one request and hold it until the block takes it
  task automatic send_req(input bin_req_t r, input bit steady);
    idle_sender(steady ? 0 : gap_len());
    push <= 1'b1;
    bin_index_i <= r.bin;
    re_part_i <= r.re;
    im_part_i <= r.im;
    mode_i <= r.learn;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_reqs++;
  endtask

  // every request has exactly one result, so an empty scoreboard plus the
  // pipeline latency means the block is idle
  task automatic wait_idle();
    idle_sender(1);
    while (scores_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // all five registers, then junk to the unused indexes, which must not alias
  task automatic apply_settings(input logic [CfgDataW-1:0] pwr_floor,
                                input logic [CfgDataW-1:0] gain,
                                input logic [CfgDataW-1:0] margin,
                                input logic [CfgDataW-1:0] shift,
                                input logic [CfgDataW-1:0] dfloor);
    cfg_write(CfgPowerFloor, pwr_floor);
    cfg_write(CfgDevGain, gain);
    cfg_write(CfgTrigMargin, margin);
    cfg_write(CfgAdaptShift, shift);
    cfg_write(CfgDevFloor, dfloor);
    for (int i = CfgFirstSpare; i < (1 << CfgIdxW); i++) begin
      cfg_write(CfgIdxW'(i), CfgDataW'($urandom));
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned count, input bit pressure);
    hot_base = $urandom_range(0, BINS - 1);
    hot_span = $urandom_range(1, 8);
    foreach (typical_amp[i]) typical_amp[i] = 1 << $urandom_range(0, 14);
    if (pressure) rx_holds_wanted++;
    // opening stretch without sender gaps; longer when the result side is held
    for (int i = 0; i < count; i++) begin
      send_req(random_req(), (i < 20) || (pressure && i < 40));
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings; baselines start at zero
    send_req(req(0, 0, 0, 0), 0);                 // zero power gives level zero
    send_req(req(2, 1, 0, 0), 0);                 // power 1, mantissa from left shift
    send_req(req(2, 0, -2, 1), 0);                // power 4
    send_req(req(2, 3, 0, 1), 0);                 // power 9, first right-shift case
    send_req(req(63, 32767, 32767, 0), 0);
    send_req(req(1, -32768, -32768, 1), 0);       // largest square sum
    send_req(req(1, -32768, 0, 1), 0);
    send_req(req(3, 255, -256, 1), 0);
    send_req(req(0, -1, -1, 0), 0);
    send_req(req(10, 0, 0, 1), 0);                // learning silence: deviation floor
    // loud learning on one bin, then quiet samples pull the mean down
    repeat (3) send_req(req(5, -20000, -20000, 1), 1);
    repeat (3) send_req(req(5, 4, 4, 1), 1);
    send_req(req(5, 4, 4, 0), 0);
    send_req(req(5, -20000, 20000, 0), 0);
    send_req(req(63, 32767, -32768, 1), 0);
    send_req(req(63, -32768, 32767, 1), 1);
    send_req(req(62, 12, -7, 0), 0);
    random_phase(RandomPhase0, 0);

    for (int p = 1; p < SettingsCount; p++) begin
      wait_idle();
      case (p)
        1: apply_settings(31'h7FFF_FFFF, 31'd255, 31'hFFFF, 31'd0, 31'hFFFF);
        2: apply_settings(31'd0, 31'd0, 31'd0, 31'd15, 31'd0);
        3: apply_settings($urandom_range(1, 4096), 31'd16, 31'd128, 31'd1, 31'd32);
        // random values, upper data bits of narrow registers included
        4: apply_settings(CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom),
                          CfgDataW'($urandom), CfgDataW'($urandom));
        default: apply_settings(31'd0, 31'(DevGainReset), 31'(TrigMarginReset), 31'd2,
                                31'(DevFloorReset));
      endcase
      if (p == 1) begin
        // floor at maximum: the sum reaches all ones, top level code
        send_req(req(0, -32768, -32768, 1), 0);
        send_req(req(0, -32768, -32768, 0), 1);
        send_req(req(1, 0, 0, 0), 0);
        send_req(req(63, 32767, 0, 1), 0);
      end else if (p == 2) begin
        send_req(req(0, 0, 0, 1), 0);
        send_req(req(0, 0, 0, 0), 1);
      end
      random_phase(RandomPerPhase, p == 2);
    end

    wait_idle();
    $display("tb_top: %0d requests under %0d register settings, %0d results compared",
             sent_reqs, SettingsCount, scores_checked);
    $display("tb_top: request side held off by full for %0d cycles", full_stall_cycles);
    if (score_fails == 0 && scores_pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // result side: random pop bursts and gaps, plus one long hold when asked
  initial begin : result_drain
    int unsigned burst, gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_holds_done != rx_holds_wanted) begin
        pop <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_holds_done++;
      end else begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
        pop <= 1'b1;
        repeat (burst) @(posedge clk_i);
        gap = gap_len();
        if (gap != 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && push && full) full_stall_cycles++;
  end

  // well beyond the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("tb_top: timed out with %0d results outstanding", scores_pending);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
